// ===== hdl/double_hash_table_engine_core_defines.svh =====
// Assertion macros shared by the hash table engine
`ifndef DOUBLE_HASH_TABLE_ENGINE_CORE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define DHTE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash table engine check failed");

// next-cycle implication, sampled on clk, off during rst
`define DHTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash table engine check failed");

`endif

// ===== hdl/dhte_pkg.sv =====
`timescale 1ns / 1ps
package dhte_pkg;

  localparam int KEY_W          = 31;
  localparam int STATUS_W       = 3;
  localparam int SLOT_W         = 4;
  localparam int OCC_W          = 4;
  localparam int S_TDATA_W      = 32;
  localparam int M_TDATA_W      = 16;
  localparam int TABLE_SIZE_DEF = 13;
  localparam int STEP_PRIME_DEF = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_FOUND    = 3'd2,
    STAT_MISS     = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_REDUCE,
    ST_PROBE,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t             command;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

endpackage

// ===== hdl/dhte_ram.sv =====
`timescale 1ns / 1ps
module dhte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dhte_residue.sv =====
`timescale 1ns / 1ps
module dhte_residue #(
  parameter int TABLE_SIZE = 13,
  parameter int STEP_PRIME = 7,
  localparam int IDX_W = $clog2(TABLE_SIZE),
  localparam int SW = $clog2(STEP_PRIME + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dhte_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [IDX_W-1:0]          home,
  output logic [SW-1:0]             rem_s
);

  import dhte_pkg::*;

  localparam int PROD_W = KEY_W + 32;
  localparam int LN     = $clog2(TABLE_SIZE);
  localparam int LS     = $clog2(STEP_PRIME);
  localparam logic [31:0] MN =
    32'(((64'd1 << (KEY_W + LN)) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
  localparam logic [31:0] MS =
    32'(((64'd1 << (KEY_W + LS)) + 64'(STEP_PRIME - 1)) / 64'(STEP_PRIME));
  localparam logic [KEY_W-1:0] NK = KEY_W'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] SK = KEY_W'(STEP_PRIME);

  logic [KEY_W-1:0]  kreg;
  logic [PROD_W-1:0] prod_n, prod_s;
  logic [KEY_W-1:0]  qn, qs, dn, ds;
  logic              mul_vld, rem_vld;
  logic [IDX_W-1:0]  rn;
  logic [SW-1:0]     rs;

  // quotient by reciprocal multiplication, exact for every key below 2**KEY_W
  assign qn = KEY_W'(prod_n >> (KEY_W + LN));
  assign qs = KEY_W'(prod_s >> (KEY_W + LS));
  assign dn = kreg - qn * NK;
  assign ds = kreg - qs * SK;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      rem_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      mul_vld <= start;
      rem_vld <= mul_vld;
      done    <= rem_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kreg <= key;
    end
    if (mul_vld) begin
      prod_n <= PROD_W'(kreg) * PROD_W'(MN);
      prod_s <= PROD_W'(kreg) * PROD_W'(MS);
    end
    if (rem_vld) begin
      rn <= dn[IDX_W-1:0];
      rs <= ds[SW-1:0];
    end
  end

  assign home  = rn;
  assign rem_s = rs;

endmodule

// ===== hdl/dhte_probe.sv =====
`timescale 1ns / 1ps
`include "double_hash_table_engine_core_defines.svh"
module dhte_probe #(
  parameter int TABLE_SIZE = 13,
  parameter int STEP_PRIME = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  dhte_pkg::request_t req,
  output logic               res_valid,
  input  logic               res_ready,
  output dhte_pkg::result_t  res
);

  import dhte_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int SW    = $clog2(STEP_PRIME + 1);
  localparam int MW    = ((SW > IDX_W) ? SW : IDX_W) + 1;
  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int PN_W  = $clog2(TABLE_SIZE + 3);
  localparam int DW    = KEY_W + 1;

  state_t           state, state_next;
  cmd_t             cmd;
  logic [KEY_W-1:0] key;
  logic [MW-1:0]    stride;
  logic [IDX_W-1:0] pos, pos_adv;
  logic [IDX_W:0]   pos_sum;
  logic [PN_W-1:0]  icnt, limit_last;
  logic             issuing;
  logic             chk_vld, chk_last;
  logic [IDX_W-1:0] chk_addr;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] clr_addr;
  result_t          res_next;
  logic             res_load;

  logic             accept, full, empty, quick, hit, miss;
  logic             mod_start, mod_done;
  logic [IDX_W-1:0] home;
  logic [SW-1:0]    rem_s;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0]    ram_wdata, ram_rdata;

  dhte_residue #(
    .TABLE_SIZE(TABLE_SIZE),
    .STEP_PRIME(STEP_PRIME)
  ) u_residue (
    .clk  (clk),
    .rst  (rst),
    .start(mod_start),
    .key  (req.key),
    .done (mod_done),
    .home (home),
    .rem_s(rem_s)
  );

  dhte_ram #(
    .WIDTH(DW),
    .DEPTH(TABLE_SIZE)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_W'(TABLE_SIZE));
  assign empty     = (count == '0);
  assign quick     = (req.command == CMD_INSERT) ? full : empty;

  assign limit_last = (cmd == CMD_INSERT) ? PN_W'(TABLE_SIZE - 1) : PN_W'(TABLE_SIZE + 1);
  assign pos_sum    = {1'b0, pos} + {1'b0, stride[IDX_W-1:0]};
  assign pos_adv    = (pos_sum >= (IDX_W + 1)'(TABLE_SIZE)) ?
                      IDX_W'(pos_sum - (IDX_W + 1)'(TABLE_SIZE)) : pos_sum[IDX_W-1:0];

  assign hit  = chk_vld && ((cmd == CMD_INSERT) ? !ram_rdata[DW-1] :
                (ram_rdata[DW-1] && (ram_rdata[KEY_W-1:0] == key)));
  assign miss = chk_vld && chk_last && !hit;

  always_comb begin
    state_next = state;
    mod_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = chk_addr;
    ram_wdata  = {1'b1, key};
    ram_re     = 1'b0;
    ram_raddr  = pos;
    res_load   = 1'b0;
    res_next   = res;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == IDX_W'(TABLE_SIZE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (quick) begin
            state_next         = ST_DONE;
            res_load           = 1'b1;
            res_next.status    = (req.command == CMD_INSERT) ? STAT_FULL : STAT_EMPTY;
            res_next.slot      = '0;
            res_next.occupancy = OCC_W'(count);
          end else begin
            mod_start  = 1'b1;
            state_next = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (mod_done) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (stride < MW'(TABLE_SIZE)) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        ram_re = issuing;
        if (hit) begin
          state_next    = ST_DONE;
          res_load      = 1'b1;
          res_next.slot = SLOT_W'(chk_addr);
          if (cmd == CMD_INSERT) begin
            ram_we             = 1'b1;
            res_next.status    = STAT_INSERTED;
            res_next.occupancy = OCC_W'(count + CNT_W'(1));
          end else begin
            res_next.status    = STAT_FOUND;
            res_next.occupancy = OCC_W'(count);
          end
        end else if (miss) begin
          state_next         = ST_DONE;
          res_load           = 1'b1;
          res_next.status    = (cmd == CMD_INSERT) ? STAT_FULL : STAT_MISS;
          res_next.slot      = '0;
          res_next.occupancy = OCC_W'(count);
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      count    <= '0;
      chk_vld  <= 1'b0;
      issuing  <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= (state == ST_PROBE) && issuing;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (state == ST_PROBE && ram_we) begin
        count <= count + CNT_W'(1);
      end
      if (state == ST_REDUCE && state_next == ST_PROBE) begin
        issuing <= 1'b1;
      end else if (state == ST_PROBE && issuing && icnt == limit_last) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= req.command;
      key <= req.key;
    end
    if (state == ST_HASH && mod_done) begin
      stride <= MW'(STEP_PRIME) - MW'(rem_s);
    end
    if (state == ST_REDUCE) begin
      if (stride >= MW'(TABLE_SIZE)) begin
        stride <= stride - MW'(TABLE_SIZE);
      end else begin
        pos  <= home;
        icnt <= '0;
      end
    end
    if (state == ST_PROBE && issuing) begin
      pos      <= pos_adv;
      icnt     <= icnt + PN_W'(1);
      chk_addr <= pos;
      chk_last <= (icnt == limit_last);
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  `DHTE_ASSERT_IMP(a_write_scope, ram_we,
      state == ST_CLEAR || (state == ST_PROBE && cmd == CMD_INSERT))
  `DHTE_ASSERT_NEXT(a_count_step, state == ST_PROBE && ram_we,
      count == $past(count) + CNT_W'(1))
  `DHTE_ASSERT_IMP(a_empty_count, state == ST_DONE && res.status == STAT_EMPTY,
      count == '0)

endmodule

// ===== hdl/double_hash_table_engine_core.sv =====
`timescale 1ns / 1ps
// Open-addressing hash table with double hashing over TABLE_SIZE slots: insert puts a key at
// key mod TABLE_SIZE and steps by STEP_PRIME - key mod STEP_PRIME until a free slot; search
// walks the same sequence for TABLE_SIZE+2 probes. After reset a clearing pass writes every
// slot invalid with s_axis_tready low. One item is in work at a time: an insert into a full
// table or a search of an empty one is answered from the occupancy count without probing; any
// other item passes the accept, the residue unit (key register, reciprocal multiply, remainder),
// stride reduction by repeated subtraction of TABLE_SIZE, one slot RAM read per probe with its
// registered read data, and the hand-off of the result to the output register. The next item
// is taken while a result still waits on m_axis_tready.
module double_hash_table_engine_core #(
  parameter int TABLE_SIZE = dhte_pkg::TABLE_SIZE_DEF,
  parameter int STEP_PRIME = dhte_pkg::STEP_PRIME_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dhte_pkg::S_TDATA_W-1:0] s_axis_tdata,  // key[30:0], zero
  input  logic                           s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dhte_pkg::M_TDATA_W-1:0] m_axis_tdata   // status, slot_index, occupancy, zero
);

  import dhte_pkg::*;

  request_t req;
  result_t  res;
  logic     res_valid;
  logic     res_ready;

  assign req.command = cmd_t'(s_axis_tuser);
  assign req.key     = s_axis_tdata[KEY_W-1:0];
  assign res_ready   = !m_axis_tvalid || m_axis_tready;

  dhte_probe #(
    .TABLE_SIZE(TABLE_SIZE),
    .STEP_PRIME(STEP_PRIME)
  ) u_probe (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_axis_tvalid),
    .req_ready(s_axis_tready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= M_TDATA_W'({res.occupancy, res.slot, res.status});
    end
  end

endmodule

// ===== verif/double_hash_table_engine_core_checker.sv =====
`timescale 1ns / 1ps
module double_hash_table_engine_core_checker
  import dhte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  output int                   mismatches,
  output int                   pending
);

  localparam int SLOTS   = TABLE_SIZE_DEF;
  localparam int STEP    = STEP_PRIME_DEF;
  localparam int SLOT_LO = STATUS_W;
  localparam int OCC_LO  = STATUS_W + SLOT_W;

  logic [KEY_W-1:0] stored_key [SLOTS];
  logic             occupied   [SLOTS];
  logic [OCC_W-1:0] fill_count;
  result_t          due_results [$];

  task automatic apply_table_op(input cmd_t op, input logic [KEY_W-1:0] key,
                                output result_t res);
    int unsigned home;
    int unsigned stride;
    int unsigned s;
    home       = key % SLOTS;
    stride     = STEP - (key % STEP);
    res.slot   = '0;
    if (op == CMD_INSERT) begin
      res.status = STAT_FULL;
      if (fill_count < SLOTS) begin
        for (int i = 0; i < SLOTS; i++) begin
          s = (home + i * stride) % SLOTS;
          if (!occupied[s]) begin
            occupied[s]   = 1'b1;
            stored_key[s] = key;
            fill_count    = fill_count + 1'b1;
            res.status    = STAT_INSERTED;
            res.slot      = s[SLOT_W-1:0];
            break;
          end
        end
      end
    end else if (fill_count == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      res.status = STAT_MISS;
      for (int i = 0; i <= SLOTS + 1; i++) begin
        s = (home + i * stride) % SLOTS;
        if (occupied[s] && stored_key[s] == key) begin
          res.status = STAT_FOUND;
          res.slot   = s[SLOT_W-1:0];
          break;
        end
      end
    end
    res.occupancy = fill_count;
  endtask

  task automatic compare_result();
    result_t want;
    status_t got_status;
    logic [SLOT_W-1:0] got_slot;
    logic [OCC_W-1:0]  got_occ;
    got_status = status_t'(m_axis_tdata[STATUS_W-1:0]);
    got_slot   = m_axis_tdata[SLOT_LO +: SLOT_W];
    got_occ    = m_axis_tdata[OCC_LO +: OCC_W];
    if (due_results.size() == 0) begin
      $error("unexpected result transfer: status %0d slot_index %0d occupancy %0d",
             got_status, got_slot, got_occ);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      if (got_status != want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got_status);
        mismatches++;
      end
      if (got_slot != want.slot) begin
        $error("slot_index: expected %0d, actual %0d", want.slot, got_slot);
        mismatches++;
      end
      if (got_occ != want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got_occ);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    result_t res;
    if (rst) begin
      foreach (occupied[i]) occupied[i] = 1'b0;
      fill_count = '0;
      due_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready) begin
        apply_table_op(cmd_t'(s_axis_tuser), s_axis_tdata[KEY_W-1:0], res);
        due_results.push_back(res);
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== verif/double_hash_table_engine_core_test.sv =====
`timescale 1ns / 1ps
module double_hash_table_engine_core_test;
  import dhte_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tready = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int               mismatches;
  int               pending;
  int               stall_cycles = 0;
  logic             steady       = 1'b0;
  logic [KEY_W-1:0] inserted_keys [$];

  double_hash_table_engine_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  double_hash_table_engine_core_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL double_hash_table_engine_core");
      $finish;
    end
  end

  task automatic send_item(input cmd_t op, input logic [KEY_W-1:0] key);
    while (!steady && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W - KEY_W){1'b0}}, key};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == CMD_INSERT) inserted_keys.push_back(key);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(3))
      0:       return r[KEY_W-1:0];
      1:       return KEY_W'($urandom_range(200));
      2:       return KEY_MAX - KEY_W'($urandom_range(200));
      default: return KEY_W'(TABLE_SIZE_DEF * $urandom_range(1000000));
    endcase
  endfunction

  initial begin
    int unsigned sel;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_SEARCH, '0);
    send_item(CMD_SEARCH, KEY_MAX);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, KEY_W'(13));
    send_item(CMD_INSERT, KEY_MAX);
    send_item(CMD_SEARCH, '0);
    send_item(CMD_SEARCH, KEY_W'(13));
    send_item(CMD_SEARCH, KEY_MAX);
    send_item(CMD_SEARCH, KEY_W'(26));
    send_item(CMD_SEARCH, KEY_W'(5));
    for (int m = 2; m <= 10; m++) send_item(CMD_INSERT, KEY_W'(13 * m));
    send_item(CMD_INSERT, KEY_W'(1));
    send_item(CMD_INSERT, KEY_MAX);
    send_item(CMD_SEARCH, KEY_W'(130));
    send_item(CMD_SEARCH, KEY_W'(143));
    send_item(CMD_SEARCH, KEY_MAX);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 700 && n < 1000);
      sel = $urandom_range(9);
      if (sel < 4) begin
        send_item(CMD_SEARCH, inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
      end else if (sel < 7) begin
        send_item(CMD_SEARCH, pick_key());
      end else begin
        send_item(CMD_INSERT, pick_key());
      end
    end
    s_axis_tvalid <= 1'b0;
    steady        <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS double_hash_table_engine_core");
    end else begin
      $display("FAIL double_hash_table_engine_core");
    end
    $finish;
  end

endmodule
